// ===== rtl/pip_pkg.sv =====
// Shared constants, codes and control structs for the point-in-polygon test core.
// No dependencies; imported by pip_ctrl, pip_dp and point_in_polygon_test_core.
`timescale 1ns / 1ps
`default_nettype none

package pip_pkg;

  localparam int unsigned MAX_VERTS_DEF  = 64;
  localparam int unsigned COORD_BITS_DEF = 16;

  localparam int unsigned OP_W     = 2;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned COUNT_W  = 7;

  localparam logic [OP_W-1:0] OP_APPEND = 2'd0;
  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd1;
  localparam logic [OP_W-1:0] OP_QUERY  = 2'd2;

  localparam logic [STATUS_W-1:0] STAT_STORED   = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_DROPPED  = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_CLEARED  = 2'd2;
  localparam logic [STATUS_W-1:0] STAT_ANSWERED = 2'd3;

  // controller -> datapath
  typedef struct packed {
    logic latch;     // capture input transaction
    logic append;    // store vertex
    logic clear;     // drop all vertices
    logic query;     // start a query
    logic rd_prime;  // read last vertex as edge start
    logic rd_edge;   // read next vertex, close one edge
    logic out_load;  // load result register
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            empty;
    logic            last;
    logic            busy;
  } sts_t;

endpackage

`default_nettype wire

// ===== rtl/pip_ctrl.sv =====
// Sequencer for the point-in-polygon test core: decode, vertex scan, result hand-off.
// Depends on pip_pkg (cmd_t, sts_t, opcodes).
`timescale 1ns / 1ps
`default_nettype none

module pip_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output pip_pkg::cmd_t  cmd_o,
  input  pip_pkg::sts_t  sts_i
);
  import pip_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_PRIME,
    ST_SCAN,
    ST_DRAIN,
    ST_RESP
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.latch = 1'b1;
          state_d     = ST_DECODE;
        end
      end
      ST_DECODE: begin
        case (sts_i.op)
          OP_APPEND: begin
            cmd_o.append = 1'b1;
            state_d      = ST_RESP;
          end
          OP_CLEAR: begin
            cmd_o.clear = 1'b1;
            state_d     = ST_RESP;
          end
          default: begin
            cmd_o.query = 1'b1;
            state_d     = sts_i.empty ? ST_RESP : ST_PRIME;
          end
        endcase
      end
      ST_PRIME: begin
        cmd_o.rd_prime = 1'b1;
        state_d        = ST_SCAN;
      end
      ST_SCAN: begin
        cmd_o.rd_edge = 1'b1;
        if (sts_i.last) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!sts_i.busy) begin
          state_d = ST_RESP;
        end
      end
      ST_RESP: begin
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign out_valid_d = cmd_o.out_load ? 1'b1 : (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> (!out_valid_q || !out_stall_i))
    else $error("result loaded over an unaccepted transaction");

  a_scan_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> !sts_i.empty)
    else $error("vertex scan on empty polygon");

  a_idle_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> !sts_i.busy)
    else $error("edge pipeline active while idle");

endmodule

`default_nettype wire

// ===== rtl/pip_dp.sv =====
// Datapath: vertex store, edge pipeline (differences, cross products, parity) and
// result register. Depends on pip_pkg; driven by pip_ctrl through cmd_t / sts_t.
`timescale 1ns / 1ps
`default_nettype none

module pip_dp #(
  parameter int unsigned MAX_VERTS  = pip_pkg::MAX_VERTS_DEF,
  parameter int unsigned COORD_BITS = pip_pkg::COORD_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic [pip_pkg::OP_W-1:0]          op_i,
  input  logic signed [COORD_BITS-1:0]      coord_x_i,
  input  logic signed [COORD_BITS-1:0]      coord_y_i,
  input  pip_pkg::cmd_t                     cmd_i,
  output pip_pkg::sts_t                     sts_o,
  output logic [pip_pkg::STATUS_W-1:0]      status_o,
  output logic                              inside_res_o,
  output logic                              on_boundary_o,
  output logic [pip_pkg::COUNT_W-1:0]       count_now_o
);
  import pip_pkg::*;

  localparam int unsigned CW = $clog2(MAX_VERTS + 1);
  localparam int unsigned AW = $clog2(MAX_VERTS);
  localparam int unsigned DW = COORD_BITS + 1;
  localparam int unsigned PW = 2 * DW;

  function automatic logic signed [DW-1:0] sx(input logic signed [COORD_BITS-1:0] v);
    return {v[COORD_BITS-1], v};
  endfunction

  logic [OP_W-1:0]              op_q;
  logic signed [COORD_BITS-1:0] qx_q, qy_q;
  logic [CW-1:0]                cnt_q;
  logic [AW-1:0]                addr_q;
  logic [CW-1:0]                cnt_m1;
  logic [AW-1:0]                last_addr, rd_addr;
  logic                         full;

  logic signed [COORD_BITS-1:0] mem_x [MAX_VERTS];
  logic signed [COORD_BITS-1:0] mem_y [MAX_VERTS];

  logic                         rd_en;
  logic signed [COORD_BITS-1:0] rdx_q, rdy_q, px_q, py_q;
  logic                         v1_q, prime1_q;

  logic                         v2_q, cross2_q, box2_q, dypos2_q;
  logic signed [DW-1:0]         dxq_q, dyb_q, dxb_q, dyq_q;
  logic                         cross_d, box_d, dypos_d;

  logic                         v3_q, cross3_q, box3_q, dypos3_q;
  logic signed [PW-1:0]         p1_q, p2_q;
  logic [PW:0]                  diff_d;
  logic                         neg, nz, toggle;

  logic                         par_q, onb_q;
  logic [STATUS_W-1:0]          res_status_q;

  assign cnt_m1    = cnt_q - CW'(1);
  assign last_addr = cnt_m1[AW-1:0];
  assign full      = (cnt_q == CW'(MAX_VERTS));
  assign rd_en     = cmd_i.rd_prime || cmd_i.rd_edge;
  assign rd_addr   = cmd_i.rd_prime ? last_addr : addr_q;

  // input capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      op_q <= op_i;
      qx_q <= coord_x_i;
      qy_q <= coord_y_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      addr_q <= '0;
    end else begin
      if (cmd_i.clear) begin
        cnt_q <= '0;
      end else if (cmd_i.append && !full) begin
        cnt_q <= cnt_q + CW'(1);
      end
      if (cmd_i.rd_prime) begin
        addr_q <= '0;
      end else if (cmd_i.rd_edge) begin
        addr_q <= addr_q + AW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.append && !full) begin
      mem_x[cnt_q[AW-1:0]] <= qx_q;
      mem_y[cnt_q[AW-1:0]] <= qy_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rdx_q <= mem_x[rd_addr];
      rdy_q <= mem_y[rd_addr];
    end
  end

  // edge stage: a = current vertex, b = previous vertex
  assign cross_d = ((rdy_q <= qy_q) && (qy_q < py_q)) || ((py_q <= qy_q) && (qy_q < rdy_q));
  assign box_d   = (((rdx_q <= qx_q) && (qx_q <= px_q)) || ((px_q <= qx_q) && (qx_q <= rdx_q)))
                && (((rdy_q <= qy_q) && (qy_q <= py_q)) || ((py_q <= qy_q) && (qy_q <= rdy_q)));
  assign dypos_d = (py_q > rdy_q);

  always_ff @(posedge clk_i) begin
    if (v1_q) begin
      px_q <= rdx_q;
      py_q <= rdy_q;
    end
    if (v1_q && !prime1_q) begin
      dxq_q    <= sx(qx_q) - sx(rdx_q);
      dyb_q    <= sx(py_q) - sx(rdy_q);
      dxb_q    <= sx(px_q) - sx(rdx_q);
      dyq_q    <= sx(qy_q) - sx(rdy_q);
      cross2_q <= cross_d;
      box2_q   <= box_d;
      dypos2_q <= dypos_d;
    end
    if (v2_q) begin
      p1_q     <= dxq_q * dyb_q;
      p2_q     <= dxb_q * dyq_q;
      cross3_q <= cross2_q;
      box3_q   <= box2_q;
      dypos3_q <= dypos2_q;
    end
  end

  // sign of (x-ax)*dy - (bx-ax)*(y-ay); zero means collinear
  assign diff_d = {p1_q[PW-1], p1_q} - {p2_q[PW-1], p2_q};
  assign neg    = diff_d[PW];
  assign nz     = |diff_d;
  assign toggle = cross3_q && (dypos3_q ? neg : (nz && !neg));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q     <= 1'b0;
      prime1_q <= 1'b0;
      v2_q     <= 1'b0;
      v3_q     <= 1'b0;
      par_q    <= 1'b0;
      onb_q    <= 1'b0;
    end else begin
      v1_q     <= rd_en;
      prime1_q <= cmd_i.rd_prime;
      v2_q     <= v1_q && !prime1_q;
      v3_q     <= v2_q;
      if (cmd_i.latch) begin
        par_q <= 1'b0;
        onb_q <= 1'b0;
      end else if (v3_q) begin
        par_q <= par_q ^ toggle;
        onb_q <= onb_q | (box3_q && !nz);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.append) begin
      res_status_q <= full ? STAT_DROPPED : STAT_STORED;
    end else if (cmd_i.clear) begin
      res_status_q <= STAT_CLEARED;
    end else if (cmd_i.query) begin
      res_status_q <= STAT_ANSWERED;
    end
    if (cmd_i.out_load) begin
      status_o      <= res_status_q;
      inside_res_o  <= par_q && !onb_q;
      on_boundary_o <= onb_q;
      count_now_o   <= COUNT_W'(cnt_q);
    end
  end

  assign sts_o.op    = op_q;
  assign sts_o.empty = (cnt_q == '0);
  assign sts_o.last  = (addr_q == last_addr);
  assign sts_o.busy  = v1_q || v2_q || v3_q;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(MAX_VERTS))
    else $error("vertex count beyond table depth");

  a_full_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.append && full) |=> $stable(cnt_q))
    else $error("append to full table changed the count");

  a_edge_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.rd_edge |-> (CW'(addr_q) < cnt_q))
    else $error("edge read past stored vertices");

endmodule

`default_nettype wire

// ===== rtl/point_in_polygon_test_core.sv =====
// Top level of the point-in-polygon test core (crossing-number rule, exact integers).
// Depends on pip_pkg, pip_ctrl and pip_dp.
//
//  channel | valid       | stall       | fields
//  --------+-------------+-------------+----------------------------------------------
//  in      | in_valid_i  | in_stall_o  | op_i, coord_x_i, coord_y_i
//  out     | out_valid_o | out_stall_i | status_o, inside_res_o, on_boundary_o,
//          |             |             | count_now_o
//
// Append, clear and a query on an empty polygon pass from acceptance through decode
// straight to the result hand-off. A query over n > 0 held vertices reads the
// vertex store once per vertex plus once for the closing edge, followed by a
// three-stage edge pipeline drain.
// Reset clears the count and control only; no clearing pass over the store.
// The next transaction is taken while a result still waits on a stalled output.
`timescale 1ns / 1ps
`default_nettype none

module point_in_polygon_test_core #(
  parameter int unsigned MAX_VERTS  = pip_pkg::MAX_VERTS_DEF,
  parameter int unsigned COORD_BITS = pip_pkg::COORD_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [pip_pkg::OP_W-1:0]      op_i,
  input  logic signed [COORD_BITS-1:0]  coord_x_i,
  input  logic signed [COORD_BITS-1:0]  coord_y_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [pip_pkg::STATUS_W-1:0]  status_o,
  output logic                          inside_res_o,
  output logic                          on_boundary_o,
  output logic [pip_pkg::COUNT_W-1:0]   count_now_o
);
  import pip_pkg::*;

  cmd_t cmd;
  sts_t sts;

  pip_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  pip_dp #(
    .MAX_VERTS  (MAX_VERTS),
    .COORD_BITS (COORD_BITS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .op_i          (op_i),
    .coord_x_i     (coord_x_i),
    .coord_y_i     (coord_y_i),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .status_o      (status_o),
    .inside_res_o  (inside_res_o),
    .on_boundary_o (on_boundary_o),
    .count_now_o   (count_now_o)
  );

endmodule

`default_nettype wire
